>>> design/fast16_corner_detector_top_macros.svh
// Assertion macros shared by the corner detector RTL.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef FAST16_CORNER_DETECTOR_TOP_MACROS_SVH
`define FAST16_CORNER_DETECTOR_TOP_MACROS_SVH

// Condition holds at every edge outside reset.
`define F16CD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define F16CD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define F16CD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/f16cd_pkg.sv
// Shared types, constants and helper functions of the FAST-16 corner detector.
// No dependencies; imported by every module of the block but f16cd_ram.
package f16cd_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int CIRCLE_POINTS = 16;
   localparam int WIN           = 7;
   localparam int RADIUS        = 3;
   localparam int WIN_LAST      = WIN - 1;
   localparam int LINE_ROWS     = WIN - 1;

   localparam int PIX_W        = 8;
   localparam int ROW_W        = 12;
   localparam int CENTER_COL_W = 11;
   localparam int CFG_W        = 12;
   localparam int MARGIN_W     = 8;
   localparam int ARC_W        = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int CMP_W        = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int RMOD_W       = $clog2(LINE_ROWS);
   localparam int CIRC_IDX_W   = $clog2(CIRCLE_POINTS);
   localparam int RUN_LEVELS   = $clog2(CIRCLE_POINTS) + 1;

   localparam int MID_DEPTH = 8;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);
   localparam int CREDIT_W  = $clog2(MID_DEPTH + 1);
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

   localparam logic [CFG_W-1:0]    RESET_IMAGE_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0]    RESET_IMAGE_HEIGHT = CFG_W'(480);
   localparam logic [MARGIN_W-1:0] RESET_MARGIN       = MARGIN_W'(20);
   localparam logic [ARC_W-1:0]    RESET_ARC_LENGTH   = ARC_W'(9);

   localparam int CIRCLE_DR [CIRCLE_POINTS] =
      '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
   localparam int CIRCLE_DC [CIRCLE_POINTS] =
      '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_BRIGHTNESS_MARGIN,
      CSR_ARC_LENGTH
   } csr_index_type;

   typedef logic [PIX_W-1:0]         pixel_type;
   typedef logic [CIRCLE_POINTS-1:0] mask_type;

   typedef struct packed {
      logic [CMP_W-1:0]    width;
      logic [ROW_W-1:0]    height;
      logic [MARGIN_W-1:0] margin;
   } front_cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [CENTER_COL_W-1:0] col;
      mask_type                bright;
      mask_type                dark;
      logic                    last;
   } cand_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [CENTER_COL_W-1:0] col;
      logic                    corner;
      logic                    last;
   } result_type;

   function automatic logic [RMOD_W-1:0] mod6_add(input logic [RMOD_W-1:0] base,
                                                  input int step);
      logic [RMOD_W:0] sum;
      sum = {1'b0, base} + (RMOD_W + 1)'(step);
      if (sum >= (RMOD_W + 1)'(LINE_ROWS)) begin
         sum = sum - (RMOD_W + 1)'(LINE_ROWS);
      end
      return sum[RMOD_W-1:0];
   endfunction

   function automatic mask_type rotr_mask(input mask_type m, input int sh);
      return (m >> sh) | (m << (CIRCLE_POINTS - sh));
   endfunction

   // Bit k-1 set when the mask holds a circular run of at least k ones.
   function automatic mask_type run_hits(input mask_type m);
      mask_type pw [RUN_LEVELS];
      mask_type acc;
      mask_type hits;
      int       off;
      pw[0] = m;
      for (int b = 1; b < RUN_LEVELS; b++) begin
         pw[b] = pw[b-1] & rotr_mask(pw[b-1], 1 << (b - 1));
      end
      for (int k = 1; k <= CIRCLE_POINTS; k++) begin
         acc = '1;
         off = 0;
         for (int b = 0; b < RUN_LEVELS; b++) begin
            if (((k >> b) & 1) != 0) begin
               acc = acc & rotr_mask(pw[b], off);
               off = off + (1 << b);
            end
         end
         hits[k-1] = |acc;
      end
      return hits;
   endfunction

endpackage

>>> design/fast16_corner_detector_top.sv
// FAST-16 corner detector, top level: configuration registers and block wiring.
// Depends on f16cd_pkg, f16cd_front, f16cd_mid_queue and f16cd_back.
//
// Usage: grayscale pixels enter in raster order through push/full; frame_start
// marks the first pixel of a frame. Each pixel at least three away from every
// border yields one result transaction (center row/col, corner flag, frame-last
// flag), read through empty/pop; border pixels yield nothing.
// A result for center (r-3, c-3) leaves with the input transaction of (r, c).
// A result passes front-end stages s1, s2 and s3, the middle queue and the
// output queue to the rsp_ ports. Throughput: one pixel per cycle unless full;
// all six line stores are read at the current column and one is written there.
// Stalls: up to 8 results wait in the middle queue and 2 in the output queue;
// full rises only once queued plus in-flight results fill the middle queue.
// Reset: raster position, queues and registers return to defaults (width 640,
// height 480, margin 20, arc 9); line stores are not cleared and hold valid
// data only once the rows above have streamed through.
// Configuration: csr_wr_en with csr_index and csr_wdata, only while idle.
module fast16_corner_detector_top
   import f16cd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [PIX_W-1:0]        req_pixel,
   input  logic                    req_frame_start,
   output logic                    empty,
   input  logic                    pop,
   output logic [ROW_W-1:0]        rsp_center_row,
   output logic [CENTER_COL_W-1:0] rsp_center_col,
   output logic                    rsp_corner_flag,
   output logic                    rsp_frame_last,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   logic [CFG_W-1:0]    width_ff;
   logic [CFG_W-1:0]    height_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [ARC_W-1:0]    arc_ff;
   front_cfg_type       front_cfg;
   logic [CMP_W-1:0]    width_ext;
   logic                cand_valid;
   cand_type            cand;
   logic                mid_empty;
   cand_type            mid_head;
   logic                mid_pop;
   result_type          result;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         margin_ff <= RESET_MARGIN;
         arc_ff    <= RESET_ARC_LENGTH;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:       width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT:      height_ff <= csr_wdata;
            CSR_BRIGHTNESS_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
            CSR_ARC_LENGTH:        arc_ff    <= csr_wdata[ARC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_ext = CMP_W'(MAX_WIDTH);
      end
      if (width_ext == '0) begin
         width_ext = CMP_W'(1);
      end
      front_cfg.width  = width_ext;
      front_cfg.height = (height_ff == '0) ? ROW_W'(1) : ROW_W'(height_ff);
      front_cfg.margin = margin_ff;
   end

   f16cd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (front_cfg),
      .push        (push),
      .full        (full),
      .pixel       (req_pixel),
      .frame_start (req_frame_start),
      .mid_pop     (mid_pop),
      .cand_valid  (cand_valid),
      .cand        (cand)
   );

   f16cd_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_valid),
      .push_data (cand),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .head      (mid_head)
   );

   f16cd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .arc_length (arc_ff),
      .head_valid (!mid_empty),
      .head       (mid_head),
      .head_pop   (mid_pop),
      .pop        (pop),
      .empty      (empty),
      .result     (result)
   );

   assign rsp_center_row  = result.row;
   assign rsp_center_col  = result.col;
   assign rsp_corner_flag = result.corner;
   assign rsp_frame_last  = result.last;

endmodule

>>> design/f16cd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; read during write to the same address returns the old data.
module f16cd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/f16cd_front.sv
// Front end: pixel intake, raster counters, line stores, 7x7 window and circle compare.
// Depends on f16cd_pkg and f16cd_ram; feeds candidate masks to the middle queue.
`include "fast16_corner_detector_top_macros.svh"

module f16cd_front
   import f16cd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  front_cfg_type cfg,
   input  logic          push,
   output logic          full,
   input  pixel_type     pixel,
   input  logic          frame_start,
   input  logic          mid_pop,
   output logic          cand_valid,
   output cand_type      cand
);

   logic [ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [COL_W-1:0]  col_ff, col_in, col_cur;
   logic [RMOD_W-1:0] rmod_ff, rmod_in, rmod_cur;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic [ROW_W:0]    row_next_ext;
   logic [CMP_W-1:0]  col_next_ext;
   logic              accept;
   logic              emit_cur;
   logic              last_cur;

   logic                    s1_valid_ff;
   logic                    s1_emit_ff;
   logic [RMOD_W-1:0]       s1_rmod_ff;
   pixel_type               s1_px_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [CENTER_COL_W-1:0] s1_col_ff;
   logic                    s1_last_ff;

   logic                    s2_valid_ff;
   logic [ROW_W-1:0]        s2_row_ff;
   logic [CENTER_COL_W-1:0] s2_col_ff;
   logic                    s2_last_ff;

   logic     s3_valid_ff;
   cand_type s3_cand_ff, s3_cand_in;

   pixel_type bank_rd [LINE_ROWS];
   pixel_type col_new [WIN];
   pixel_type window_ff [WIN][WIN];
   pixel_type circ [CIRCLE_POINTS];
   pixel_type center;
   mask_type  bright_mask;
   mask_type  dark_mask;

   assign full   = (credit_ff == CREDIT_W'(MID_DEPTH));
   assign accept = push && !full;

   always_comb begin
      row_cur  = frame_start ? '0 : row_ff;
      col_cur  = frame_start ? '0 : col_ff;
      rmod_cur = frame_start ? '0 : rmod_ff;
      if (CMP_W'(col_cur) >= cfg.width) begin
         col_cur = '0;
      end
      if (row_cur >= cfg.height) begin
         row_cur  = '0;
         rmod_cur = '0;
      end
      row_next_ext = {1'b0, row_cur} + (ROW_W + 1)'(1);
      col_next_ext = CMP_W'(col_cur) + CMP_W'(1);
      emit_cur = (row_cur >= ROW_W'(WIN_LAST)) && (col_cur >= COL_W'(WIN_LAST));
      last_cur = (row_next_ext == {1'b0, cfg.height}) && (col_next_ext == cfg.width);
      row_in  = row_cur;
      rmod_in = rmod_cur;
      if (col_next_ext >= cfg.width) begin
         col_in = '0;
         if (row_next_ext >= {1'b0, cfg.height}) begin
            row_in  = '0;
            rmod_in = '0;
         end else begin
            row_in  = row_next_ext[ROW_W-1:0];
            rmod_in = (rmod_cur == RMOD_W'(LINE_ROWS - 1)) ? '0 : rmod_cur + 1'b1;
         end
      end else begin
         col_in = col_next_ext[COL_W-1:0];
      end
   end

   always_comb begin
      credit_in = credit_ff;
      if (accept && emit_cur) begin
         credit_in = credit_in + 1'b1;
      end
      if (mid_pop) begin
         credit_in = credit_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         rmod_ff     <= '0;
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            rmod_ff <= rmod_in;
         end
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
      f16cd_ram #(
         .DATA_W (PIX_W),
         .DEPTH  (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (accept && (rmod_cur == RMOD_W'(b))),
         .wr_addr (col_cur),
         .wr_data (pixel),
         .rd_addr (col_cur),
         .rd_data (bank_rd[b])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit_cur;
         s1_rmod_ff <= rmod_cur;
         s1_px_ff   <= pixel;
         s1_row_ff  <= ROW_W'(row_cur - ROW_W'(RADIUS));
         s1_col_ff  <= CENTER_COL_W'(col_cur - COL_W'(RADIUS));
         s1_last_ff <= last_cur;
      end
   end

   // Oldest row on top; banks rotate with the row index mod six.
   always_comb begin
      for (int y = 0; y < LINE_ROWS; y++) begin
         col_new[y] = bank_rd[mod6_add(s1_rmod_ff, y)];
      end
      col_new[WIN_LAST] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int y = 0; y < WIN; y++) begin
            for (int x = 0; x < WIN_LAST; x++) begin
               window_ff[y][x] <= window_ff[y][x+1];
            end
            window_ff[y][WIN_LAST] <= col_new[y];
         end
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      center = window_ff[RADIUS][RADIUS];
      for (int i = 0; i < CIRCLE_POINTS; i++) begin
         circ[i] = window_ff[RADIUS + CIRCLE_DR[i]][RADIUS + CIRCLE_DC[i]];
         bright_mask[i] = {1'b0, circ[i]} > ({1'b0, center} + {1'b0, cfg.margin});
         dark_mask[i]   = ({1'b0, circ[i]} + {1'b0, cfg.margin}) < {1'b0, center};
      end
      s3_cand_in.row    = s2_row_ff;
      s3_cand_in.col    = s2_col_ff;
      s3_cand_in.bright = bright_mask;
      s3_cand_in.dark   = dark_mask;
      s3_cand_in.last   = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         s3_cand_ff <= s3_cand_in;
      end
   end

   assign cand_valid = s3_valid_ff;
   assign cand       = s3_cand_ff;

   `F16CD_ASSERT_ALWAYS(a_credit_bound, credit_ff <= CREDIT_W'(MID_DEPTH),
      "queue credit above depth")
   `F16CD_ASSERT_IMPLY(a_credit_pop, mid_pop, credit_ff != '0,
      "queue pop without outstanding credit")

endmodule

>>> design/f16cd_mid_queue.sv
// Middle queue of candidate transactions between front end and back end.
// Depends on f16cd_pkg; space is guaranteed by the front-end credit counter.
`include "fast16_corner_detector_top_macros.svh"

module f16cd_mid_queue
   import f16cd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cand_type push_data,
   input  logic     pop,
   output logic     empty,
   output cand_type head
);

   cand_type             entry_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0] wr_ptr_ff;
   logic [MID_PTR_W-1:0] rd_ptr_ff;
   logic [MID_PTR_W:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   `F16CD_ASSERT_IMPLY(a_mid_no_overflow, push && !pop,
      count_ff < (MID_PTR_W + 1)'(MID_DEPTH), "middle queue overflow")
   `F16CD_ASSERT_IMPLY(a_mid_no_underflow, pop, !empty, "middle queue underflow")

endmodule

>>> design/f16cd_back.sv
// Back end: circular run test on candidate masks and the result output queue.
// Depends on f16cd_pkg; drains the middle queue as output space allows.
module f16cd_back
   import f16cd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [ARC_W-1:0] arc_length,
   input  logic             head_valid,
   input  cand_type         head,
   output logic             head_pop,
   input  logic             pop,
   output logic             empty,
   output result_type       result
);

   result_type           entry_ff [OUT_DEPTH];
   result_type           res_in;
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_PTR_W:0]   count_ff, count_in;
   mask_type             bright_hits;
   mask_type             dark_hits;
   logic [CIRC_IDX_W-1:0] arc_idx;
   logic                 corner;
   logic                 pop_ok;
   logic                 space;

   always_comb begin
      bright_hits = run_hits(head.bright);
      dark_hits   = run_hits(head.dark);
      arc_idx     = CIRC_IDX_W'(arc_length - ARC_W'(1));
      if (arc_length == '0) begin
         corner = 1'b1;
      end else if (arc_length > ARC_W'(CIRCLE_POINTS)) begin
         corner = 1'b0;
      end else begin
         corner = bright_hits[arc_idx] || dark_hits[arc_idx];
      end
      res_in.row    = head.row;
      res_in.col    = head.col;
      res_in.corner = corner;
      res_in.last   = head.last;
   end

   assign pop_ok   = pop && !empty;
   assign space    = (count_ff != (OUT_PTR_W + 1)'(OUT_DEPTH)) || pop_ok;
   assign head_pop = head_valid && space;

   always_comb begin
      count_in = count_ff;
      if (head_pop && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (head_pop) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         entry_ff[wr_ptr_ff] <= res_in;
      end
   end

   assign empty  = (count_ff == '0);
   assign result = entry_ff[rd_ptr_ff];

endmodule
